@@ src/assert_macros.svh @@
// Assertion macros for the RTL of the token classifier.
// Self-contained; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/ltc_pkg.sv @@
// Types, character codes and keyword table of the token classifier.
// No dependencies; used by the interfaces and all modules.
package ltc_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned ClassW     = 5;
  localparam int unsigned WordLenW   = 4;
  localparam int unsigned NumKw      = 32;
  localparam int unsigned KwMaxChars = 9;
  localparam int unsigned KwTextW    = 8 * KwMaxChars;
  localparam int unsigned VarLen     = 3;
  localparam int unsigned VarProgW   = 2;

  // Character codes
  localparam logic [CharW-1:0] ChSpace   = 8'd32;
  localparam logic [CharW-1:0] ChTab     = 8'd9;
  localparam logic [CharW-1:0] ChCr      = 8'd13;
  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChNine    = 8'h39;
  localparam logic [CharW-1:0] ChDot     = 8'h2e;

  // Prefix that marks a variable
  localparam logic [CharW-1:0] VAR_CHARS [VarLen] = '{8'h56, 8'h41, 8'h52};

  // Token classes produced outside the table lookup
  localparam logic [ClassW-1:0] CodeInt   = 5'd25;
  localparam logic [ClassW-1:0] CodeFloat = 5'd26;
  localparam logic [ClassW-1:0] CodeVar   = 5'd31;

  // Keyword / operator table, text right-aligned, zero padded on the left
  localparam logic [KwTextW-1:0] KW_TEXT [NumKw] = '{
    72'("("), 72'(")"), 72'("{"), 72'("}"), 72'("["), 72'("]"),
    72'("=="), 72'("="), 72'(">="), 72'("<="), 72'(">"), 72'("<"),
    72'("!"), 72'(","), 72'(";"), 72'("If"), 72'("+"), 72'("-"),
    72'("*"), 72'("/"), 72'("%"), 72'("int"), 72'("float"),
    72'("&&"), 72'("||"), 72'("NUM_INT"), 72'({"NUM_", "FLOAT"}), 72'("!="),
    72'("char"), 72'("bool"), 72'("return"), 72'("VAR")
  };

  localparam logic [WordLenW-1:0] KW_LEN [NumKw] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd3, 4'd5,
    4'd2, 4'd2, 4'd7, 4'd9, 4'd2,
    4'd4, 4'd4, 4'd6, 4'd3
  };

  // Character of table entry k at word position pos (zero past its end)
  function automatic logic [CharW-1:0] kw_char(input int unsigned k,
                                               input logic [WordLenW-1:0] pos);
    logic [KwTextW-1:0] t;
    logic [CharW-1:0]   c;
    t = KW_TEXT[k] << (8 * (KwMaxChars - int'(KW_LEN[k])));
    c = '0;
    if (pos < KW_LEN[k]) begin
      c = t[KwTextW - 1 - 8 * int'(pos) -: 8];
    end
    return c;
  endfunction

  // Accepted character as held in the input register
  typedef struct packed {
    logic             vld;
    logic [CharW-1:0] ch;
    logic             eoi;
  } ltc_item_t;

  // Classification result of one character
  typedef struct packed {
    logic              emit;
    logic [ClassW-1:0] cls;
  } ltc_res_t;

endpackage

@@ src/ltc_char_if.sv @@
// Request channel carrying one character and the end-of-input flag.
// Depends on ltc_pkg.
interface ltc_char_if;
  import ltc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_in;
  logic             end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

@@ src/ltc_token_if.sv @@
// Request channel carrying one token class code.
// Depends on ltc_pkg.
interface ltc_token_if;
  import ltc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ClassW-1:0] token_class;

  modport source (output valid, output token_class, input ready);
  modport sink   (input valid, input token_class, output ready);
endinterface

@@ src/lexical_token_classifier_unit.sv @@
// Token classifier top: characters in, a token class out when a word with
// a class ends, through the input and output registers.
// Throughput: one char per cycle unless stalled, set by word-state update.
// Reset (async, active low) empties both registers and closes any open word.
// Depends on ltc_pkg, the two channel interfaces and the three stages.
module lexical_token_classifier_unit #(
  parameter int unsigned MAX_KEYWORD_LEN = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ltc_char_if.sink    char_i,
  ltc_token_if.source token_o
);
  import ltc_pkg::*;

  ltc_item_t item;
  ltc_res_t  res;
  logic      out_free;
  logic      adv;

  // Held character moves on once the output slot can take its result
  assign adv = item.vld && out_free;

  ltc_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_i),
    .adv_i  (adv),
    .item_o (item)
  );

  ltc_word_unit #(
    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
  ) u_word (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .adv_i  (adv),
    .res_o  (res)
  );

  ltc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .adv_i   (adv),
    .free_o  (out_free),
    .token_o (token_o)
  );
endmodule

@@ src/ltc_in_stage.sv @@
// Input register of the token classifier: holds one accepted character.
// Depends on ltc_pkg and ltc_char_if.
module ltc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  ltc_char_if.sink          char_i,
  input  logic              adv_i,
  output ltc_pkg::ltc_item_t item_o
);
  import ltc_pkg::*;

  logic             vld_q, vld_d;
  logic [CharW-1:0] ch_q;
  logic             eoi_q;
  logic             take;

  // Slot frees when the held character moves on
  assign char_i.ready = !vld_q || adv_i;
  assign take         = char_i.valid && char_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (adv_i) vld_d = 1'b0;
    if (take)  vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      ch_q  <= char_i.char_in;
      eoi_q <= char_i.end_of_input;
    end
  end

  assign item_o = '{vld: vld_q, ch: ch_q, eoi: eoi_q};
endmodule

@@ src/ltc_word_unit.sv @@
// Word state and classification: tracks the open word one character at a
// time and decides the token class when it ends. Depends on ltc_pkg.
`include "assert_macros.svh"
module ltc_word_unit #(
  parameter int unsigned MAX_KEYWORD_LEN = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ltc_pkg::ltc_item_t item_i,
  input  logic               adv_i,
  output ltc_pkg::ltc_res_t  res_o
);
  import ltc_pkg::*;

  localparam logic [WordLenW-1:0] MaxLen = WordLenW'(MAX_KEYWORD_LEN);

  // Word state
  logic [NumKw-1:0]    cand_q, cand_d;
  logic [WordLenW-1:0] len_q, len_d;
  logic                digits_q, digits_d;
  logic                dot_q, dot_d;
  logic                broken_q, broken_d;
  logic [VarProgW-1:0] var_q, var_d;
  logic                open_q, open_d;

  // State after taking the current character
  logic [NumKw-1:0]    cand_t;
  logic [WordLenW-1:0] len_t;
  logic                digits_t, dot_t, broken_t;
  logic [VarProgW-1:0] var_t;

  // State the word is finished from
  logic [NumKw-1:0]    cand_s;
  logic [WordLenW-1:0] len_s;
  logic                digits_s, dot_s, broken_s, open_s, var_done_s;
  logic [VarProgW-1:0] var_s;

  logic              space, digit, is_dot, finish;
  logic [NumKw-1:0]  hit;
  logic [ClassW-1:0] kw_cls, cls;
  logic              kw_hit;

  assign space  = (item_i.ch == ChSpace) || (item_i.ch >= ChTab && item_i.ch <= ChCr);
  assign digit  = (item_i.ch >= ChZero) && (item_i.ch <= ChNine);
  assign is_dot = (item_i.ch == ChDot);
  assign finish = space || item_i.eoi;

  // Take one character
  always_comb begin
    cand_t = cand_q;
    if (len_q >= MaxLen) begin
      cand_t = '0;
    end else begin
      for (int unsigned k = 0; k < NumKw; k++) begin
        if (len_q >= KW_LEN[k] || kw_char(k, len_q) != item_i.ch) cand_t[k] = 1'b0;
      end
    end

    digits_t = digits_q && digit;
    dot_t    = dot_q || is_dot;
    broken_t = broken_q || (is_dot ? dot_q : !digit);

    var_t = var_q;
    if (var_q < VarProgW'(VarLen) && WordLenW'(var_q) == len_q
        && VAR_CHARS[var_q] == item_i.ch) begin
      var_t = var_q + 1'b1;
    end

    len_t = (len_q < MaxLen) ? len_q + 1'b1 : len_q;
  end

  // Whitespace finishes the word as it stands, other characters first join it
  always_comb begin
    if (space) begin
      cand_s = cand_q; len_s = len_q; digits_s = digits_q; dot_s = dot_q;
      broken_s = broken_q; var_s = var_q; open_s = open_q;
    end else begin
      cand_s = cand_t; len_s = len_t; digits_s = digits_t; dot_s = dot_t;
      broken_s = broken_t; var_s = var_t; open_s = 1'b1;
    end
    var_done_s = (var_s == VarProgW'(VarLen));
  end

  // Table lookup: lowest surviving entry of matching length
  always_comb begin
    kw_cls = '0;
    for (int unsigned k = 0; k < NumKw; k++) begin
      hit[k] = cand_s[k] && (KW_LEN[k] == len_s);
    end
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (hit[k]) kw_cls = ClassW'(k);
    end
    kw_hit = |hit;
  end

  // Class decision in fixed test order
  always_comb begin
    if (digits_s) begin
      cls = CodeInt;
    end else if (!broken_s && dot_s && len_s > WordLenW'(1)) begin
      cls = CodeFloat;
    end else if (var_done_s) begin
      cls = CodeVar;
    end else begin
      cls = kw_cls;
    end
  end

  assign res_o.emit = item_i.vld && finish && open_s
                      && (digits_s || (!broken_s && dot_s && len_s > WordLenW'(1))
                          || var_done_s || kw_hit);
  assign res_o.cls  = cls;

  // Next word state
  always_comb begin
    cand_d = cand_q; len_d = len_q; digits_d = digits_q; dot_d = dot_q;
    broken_d = broken_q; var_d = var_q; open_d = open_q;
    if (adv_i) begin
      if (finish) begin
        cand_d = '1; len_d = '0; digits_d = 1'b1; dot_d = 1'b0;
        broken_d = 1'b0; var_d = '0; open_d = 1'b0;
      end else begin
        cand_d = cand_t; len_d = len_t; digits_d = digits_t; dot_d = dot_t;
        broken_d = broken_t; var_d = var_t; open_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q   <= '1;
      len_q    <= '0;
      digits_q <= 1'b1;
      dot_q    <= 1'b0;
      broken_q <= 1'b0;
      var_q    <= '0;
      open_q   <= 1'b0;
    end else begin
      cand_q   <= cand_d;
      len_q    <= len_d;
      digits_q <= digits_d;
      dot_q    <= dot_d;
      broken_q <= broken_d;
      var_q    <= var_d;
      open_q   <= open_d;
    end
  end

  // A closed word leaves no length behind
  `ASSERT_IMPLIES(a_closed_len, clk_i, rst_ni, !open_q, len_q == '0 && var_q == '0)
  // An all-digit word can never be a broken number
  `ASSERT_IMPLIES(a_digits_unbroken, clk_i, rst_ni, digits_q, !broken_q && !dot_q)
  // Prefix progress never runs ahead of the word length
  `ASSERT_ALWAYS(a_var_len, clk_i, rst_ni, WordLenW'(var_q) <= len_q)
endmodule

@@ src/ltc_out_stage.sv @@
// Output register of the token classifier: holds one token class request.
// Depends on ltc_pkg and ltc_token_if.
module ltc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ltc_pkg::ltc_res_t res_i,
  input  logic              adv_i,
  output logic              free_o,
  ltc_token_if.source       token_o
);
  import ltc_pkg::*;

  logic              vld_q, vld_d;
  logic [ClassW-1:0] cls_q;
  logic              load;

  assign free_o = !vld_q || token_o.ready;
  assign load   = adv_i && res_i.emit;

  always_comb begin
    vld_d = vld_q;
    if (token_o.ready) vld_d = 1'b0;
    if (load)          vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cls_q <= res_i.cls;
  end

  assign token_o.valid       = vld_q;
  assign token_o.token_class = cls_q;
endmodule

@@ bench/tb.sv @@
// Self-checking bench for lexical_token_classifier_unit: character requests in,
// token class requests out, checked against an in-bench classifier model.
// Depends on ltc_pkg, ltc_char_if, ltc_token_if and the RTL top level.

// Whitespace ends a word: tab through carriage return, and space
function automatic bit is_blank(logic [7:0] c);
  return c == ltc_pkg::ChSpace || (c >= ltc_pkg::ChTab && c <= ltc_pkg::ChCr);
endfunction

// Word classifier model plus the queue of token classes it still awaits
class token_scoreboard #(int MaxLen = 9);
  string             kw_words [ltc_pkg::NumKw];
  string             var_word;
  logic [31:0]       cand;
  logic [3:0]        wlen;
  bit                only_dig;
  bit                dot;
  bit                broken;
  logic [2:0]        var_prog;
  bit                open;
  logic [4:0]        awaited [$];
  int                errors;

  function new();
    kw_words = '{"(", ")", "{", "}", "[", "]", "==", "=", ">=", "<=", ">", "<",
                 "!", ",", ";", "If", "+", "-", "*", "/", "%", "int", "float",
                 "&&", "||", "NUM_INT", "", "!=", "char", "bool",
                 "return", "VAR"};
    // float entry shares the stem of the integer entry
    kw_words[ltc_pkg::CodeFloat] = {kw_words[ltc_pkg::CodeInt].substr(0, 3), "FLOAT"};
    var_word = "VAR";
    errors = 0;
    clear_word();
  endfunction

  function void clear_word();
    cand     = '1;
    wlen     = '0;
    only_dig = 1'b1;
    dot      = 1'b0;
    broken   = 1'b0;
    var_prog = '0;
    open     = 1'b0;
  endfunction

  function void take_char(logic [7:0] c);
    bit digit;
    digit = c >= ltc_pkg::ChZero && c <= ltc_pkg::ChNine;
    // keyword match column by column; words past the longest entry match nothing
    if (wlen >= MaxLen) begin
      cand = '0;
    end else begin
      for (int k = 0; k < ltc_pkg::NumKw; k++) begin
        if (int'(wlen) >= kw_words[k].len() || kw_words[k][wlen] != c) cand[k] = 1'b0;
      end
    end
    if (!digit) only_dig = 1'b0;
    if (c == ltc_pkg::ChDot) begin
      if (dot) broken = 1'b1;
      dot = 1'b1;
    end else if (!digit) begin
      broken = 1'b1;
    end
    // prefix only advances while it is contiguous from the first character
    if (var_prog < 3 && var_prog == wlen && var_word[var_prog] == c) var_prog++;
    if (wlen < MaxLen) wlen++;
    open = 1'b1;
  endfunction

  // Word end: integer, float, variable, then exact table lookup
  function void close_word();
    bit found;
    found = 1'b0;
    if (open) begin
      if (only_dig) begin
        awaited.push_back(ltc_pkg::CodeInt);
      end else if (!broken && dot && wlen > 1) begin
        awaited.push_back(ltc_pkg::CodeFloat);
      end else if (var_prog >= 3) begin
        awaited.push_back(ltc_pkg::CodeVar);
      end else begin
        for (int k = 0; k < ltc_pkg::NumKw; k++) begin
          if (!found && cand[k] && kw_words[k].len() == int'(wlen)) begin
            awaited.push_back(5'(k));
            found = 1'b1;
          end
        end
      end
    end
    clear_word();
  endfunction

  // Accepted character request
  function void note_char(logic [7:0] c, logic eoi);
    if (is_blank(c)) begin
      close_word();
    end else begin
      take_char(c);
      if (eoi) close_word();
    end
  endfunction

  // Accepted token request
  function void check_token(logic [4:0] got);
    logic [4:0] want;
    if (awaited.size() == 0) begin
      $error("token_class: nothing expected, actual %0d", got);
      errors++;
    end else begin
      want = awaited.pop_front();
      if (got !== want) begin
        $error("token_class: expected %0d, actual %0d", want, got);
        errors++;
      end
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module tb;
  import ltc_pkg::*;

  localparam int MaxKwLen    = 9;
  localparam int NumChars    = 1850;
  localparam int LimitCycles = 1000000;
  localparam int DrainCycles = 8;

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   sent;
  int   stall_left = 0;
  bit   quiet;

  token_scoreboard #(MaxKwLen) sb;

  ltc_char_if  char_bus ();
  ltc_token_if tok_bus ();

  lexical_token_classifier_unit #(
    .MAX_KEYWORD_LEN(MaxKwLen)
  ) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_bus),
    .token_o(tok_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none, some short, a few long; none in quiet stretches
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_blank(c));
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    int idx;
    idx = $urandom_range(0, 5);
    return idx < 5 ? ChTab + 8'(idx) : ChSpace;
  endfunction

  function automatic logic [7:0] digit_byte();
    return ChZero + 8'($urandom_range(0, 9));
  endfunction

  // Token sink with random stalls; also counts cycles for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (tok_bus.valid && tok_bus.ready) sb.check_token(tok_bus.token_class);
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        tok_bus.ready <= 1'b0;
      end else begin
        tok_bus.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = idle_gap();
      end
    end else begin
      tok_bus.ready <= 1'b0;
    end
  end

  initial begin
    wait (cycle_count >= LimitCycles);
    $display("tb: errors");
    $finish;
  end

  // One character request, held until accepted
  task automatic send_char(input logic [7:0] c, input logic eoi);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_bus.valid        <= 1'b1;
    char_bus.char_in      <= c;
    char_bus.end_of_input <= eoi;
    do @(posedge clk); while (!char_bus.ready);
    sb.note_char(c, eoi);
    sent++;
  endtask

  task automatic send_text(input string s, input bit eoi_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eoi_last && i == s.len() - 1);
  endtask

  // One random word of a chosen shape, then its separator unless it ends input
  task automatic random_word();
    logic [7:0] w [$];
    string      kw;
    int         r;
    int         n;
    int         pos;
    bit         eoi_end;
    r = $urandom_range(0, 99);
    kw = sb.kw_words[$urandom_range(0, NumKw - 1)];
    eoi_end = 1'b0;
    if (r < 35) begin
      // table entry, sometimes slightly off
      for (int i = 0; i < kw.len(); i++) w.push_back(kw[i]);
      case ($urandom_range(0, 9))
        0: if (w.size() > 1) void'(w.pop_back());
        1: w.push_back(word_byte());
        2: begin
          pos = $urandom_range(0, w.size() - 1);
          w[pos] = word_byte();
        end
        default: ;
      endcase
    end else if (r < 50) begin
      n = $urandom_range(1, 12);
      repeat (n) w.push_back(digit_byte());
    end else if (r < 62) begin
      repeat ($urandom_range(0, 4)) w.push_back(digit_byte());
      w.push_back(ChDot);
      repeat ($urandom_range(0, 4)) w.push_back(digit_byte());
      if ($urandom_range(0, 6) == 0) w.insert($urandom_range(0, w.size()), ChDot);
      if ($urandom_range(0, 9) == 0) w.insert($urandom_range(0, w.size()), word_byte());
    end else if (r < 72) begin
      case ($urandom_range(0, 4))
        0: w = '{"V", "A"};
        1: w = '{word_byte(), "V", "A", "R"};
        default: w = '{"V", "A", "R"};
      endcase
      repeat ($urandom_range(0, 8)) w.push_back(word_byte());
    end else if (r < 82) begin
      // near or past the longest table entry
      if ($urandom_range(0, 1)) begin
        kw = sb.kw_words[$urandom_range(0, 1) ? CodeFloat : CodeInt];
        for (int i = 0; i < kw.len(); i++) w.push_back(kw[i]);
        repeat ($urandom_range(0, 5)) w.push_back(word_byte());
      end else begin
        repeat ($urandom_range(8, 15)) w.push_back(word_byte());
      end
    end else if (r < 92) begin
      repeat ($urandom_range(1, 6)) w.push_back(word_byte());
    end else if (r < 96) begin
      w.push_back(ChDot);
    end
    foreach (w[i]) begin
      eoi_end = i == w.size() - 1 && $urandom_range(0, 9) == 0;
      send_char(w[i], eoi_end);
    end
    if (!eoi_end) begin
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) send_char(blank_byte(), i == n - 1 && $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    sb = new();
    rst_n                 = 1'b0;
    sent                  = 0;
    quiet                 = 1'b0;
    char_bus.valid        = 1'b0;
    char_bus.char_in      = '0;
    char_bus.end_of_input = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: operator, float flushed by end of input, variable, extreme bytes,
    // empty word, longest keyword and a word one past it
    send_text("==", 1'b0);
    send_char(ChCr, 1'b0);
    send_text("3.5", 1'b1);
    send_text("VAR1 ", 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(ChSpace, 1'b1);
    send_char(8'd11, 1'b1);
    send_text(sb.kw_words[CodeFloat], 1'b0);
    send_char(8'd10, 1'b0);
    send_text({sb.kw_words[CodeFloat], "!"}, 1'b0);
    send_char(8'd10, 1'b0);

    // Random words, with quiet stretches of back-to-back traffic
    while (sent < NumChars) begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      random_word();
    end
    char_bus.valid <= 1'b0;
    quiet = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
